@@ rtl/core/smm_pkg.sv @@
// Package: shared types and constants of the sliding min/max filter.
package smm_pkg;

    // Half-window registers
    localparam int HW_CFG_BITS  = 5;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HW_PLANE0 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HW_PLANE1 = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HW_PLANE2 = 2'd2;

    localparam logic [HW_CFG_BITS-1:0] HW_RESET = 5'd4;

    // Plane codes; plane 3 shares the plane 2 setting
    localparam int PLANE_BITS = 2;
    localparam logic [PLANE_BITS-1:0] PLANE0 = 2'd0;
    localparam logic [PLANE_BITS-1:0] PLANE1 = 2'd1;

    // Control of one beat group handed to the output stage
    typedef struct packed {
        logic load;       // take a new group this cycle
        logic final_grp;  // group ends the waveform
    } smm_load_t;

endpackage

@@ rtl/core/sliding_min_max_erosion_dilation.sv @@
// Top level: streaming sliding-window erosion/dilation over a cell chain.
// Throughput: one sample per cycle while in_stall is low; each sample that closes
// a window gives one beat, offered once it has passed the holding and output stages.
// The last sample adds a burst of hw more beats (or the whole short waveform),
// during which input stalls once the one-item holding stage fills.
// Reset (rst_n, async, active low): empties both stages, half windows back to 4.
module sliding_min_max_erosion_dilation
    import smm_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [HW_CFG_BITS-1:0]        cfg_data,
    // sample input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [PLANE_BITS-1:0]         plane,
    input  logic                          last_sample,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] erosion,
    output logic signed [SAMPLE_BITS-1:0] dilation,
    output logic signed [SAMPLE_BITS:0]   average_times_two,
    output logic [SAMPLE_BITS-1:0]        spread,
    output logic                          last_result
);

    localparam int DEPTH    = 2 * MAX_HALF_WINDOW;
    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int HW_BITS  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SEEN_BITS = $clog2(DEPTH + 2);
    localparam int CNT_BITS = $clog2(MAX_HALF_WINDOW + 2);
    localparam int CMP_BITS = (HW_BITS > HW_CFG_BITS) ? HW_BITS : HW_CFG_BITS;
    localparam int SEEN_LIMIT = DEPTH + 1;

    // Registered half windows, raw as written.
    logic [HW_CFG_BITS-1:0] hw0_reg;
    logic [HW_CFG_BITS-1:0] hw1_reg;
    logic [HW_CFG_BITS-1:0] hw2_reg;

    // Per-waveform tracking: saturating sample count and the latched half window.
    logic [SEEN_BITS-1:0] seen_reg;
    logic [SEEN_BITS-1:0] seen_inc;
    logic [HW_BITS-1:0]   hw_reg;
    logic [HW_BITS-1:0]   hw_cur;
    logic [HW_CFG_BITS-1:0] hw_pick;
    logic                 start;
    logic                 accept;
    logic                 long_enough;
    logic [CNT_BITS-1:0]  count;

    // Holding stage between the chain and the output stage.
    logic                 a_valid_reg;
    logic [CNT_BITS-1:0]  a_count_reg;
    logic                 a_final_reg;
    logic [IDX_BITS-1:0]  a_sel_reg;
    logic                 a_move;
    logic                 b_ready;
    smm_load_t            load_ctl;

    // Chain of cells: cell k holds min/max of the newest k+1 samples of the
    // current waveform (or all of them when fewer have arrived).
    logic signed [SAMPLE_BITS-1:0] cell_min [DEPTH];
    logic signed [SAMPLE_BITS-1:0] cell_max [DEPTH];

    function automatic logic [HW_BITS-1:0] clamp_hw(input logic [HW_CFG_BITS-1:0] v);
        logic [CMP_BITS-1:0] v_ext;
        logic [HW_BITS-1:0]  r;
        v_ext = CMP_BITS'(v);
        if (v_ext == '0)
            r = HW_BITS'(1);
        else if (v_ext > CMP_BITS'(MAX_HALF_WINDOW))
            r = HW_BITS'(MAX_HALF_WINDOW);
        else
            r = HW_BITS'(v_ext);
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw0_reg <= HW_RESET;
            hw1_reg <= HW_RESET;
            hw2_reg <= HW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HW_PLANE0: hw0_reg <= cfg_data;
                CFG_HW_PLANE1: hw1_reg <= cfg_data;
                CFG_HW_PLANE2: hw2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input side ----------------
    always_comb
    begin
        case (plane)
            PLANE0:  hw_pick = hw0_reg;
            PLANE1:  hw_pick = hw1_reg;
            default: hw_pick = hw2_reg;
        endcase
    end

    assign start    = (seen_reg == '0);
    assign hw_cur   = start ? clamp_hw(hw_pick) : hw_reg;
    assign seen_inc = (seen_reg < SEEN_BITS'(SEEN_LIMIT)) ? seen_reg + SEEN_BITS'(1)
                                                          : seen_reg;
    assign long_enough = (seen_inc > SEEN_BITS'(hw_cur));

    // beats caused by this sample
    always_comb
    begin
        if (long_enough)
            count = last_sample ? CNT_BITS'(hw_cur) + CNT_BITS'(1) : CNT_BITS'(1);
        else if (last_sample)
            count = CNT_BITS'(seen_inc);  // short waveform: one beat per sample
        else
            count = '0;
    end

    assign in_stall = a_valid_reg && !b_ready;
    assign accept   = in_valid && !in_stall;
    assign a_move   = a_valid_reg && b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            hw_reg      <= HW_BITS'(1);
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            seen_reg    <= last_sample ? '0 : seen_inc;
            hw_reg      <= hw_cur;
            a_valid_reg <= (count != '0);
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // window length 2*hw always lands on the right cell: shorter histories
    // saturate the deeper cells at the whole-waveform min/max
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_count_reg <= count;
            a_final_reg <= last_sample;
            a_sel_reg   <= IDX_BITS'({hw_cur, 1'b0} - (HW_BITS + 1)'(1));
        end
    end

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            smm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk      (clk),
                .en       (accept),
                .start    (start),
                .sample   (sample),
                .prev_min (sample),
                .prev_max (sample),
                .cell_min (cell_min[k]),
                .cell_max (cell_max[k])
            );
        end
        else
        begin : g_body
            smm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk      (clk),
                .en       (accept),
                .start    (start),
                .sample   (sample),
                .prev_min (cell_min[k-1]),
                .prev_max (cell_max[k-1]),
                .cell_min (cell_min[k]),
                .cell_max (cell_max[k])
            );
        end
    end

    // ---------------- output stage ----------------
    assign load_ctl.load      = a_move;
    assign load_ctl.final_grp = a_final_reg;

    smm_burst #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_burst (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (load_ctl),
        .load_count        (a_count_reg),
        .load_min          (cell_min[a_sel_reg]),
        .load_max          (cell_max[a_sel_reg]),
        .ready             (b_ready),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .erosion           (erosion),
        .dilation          (dilation),
        .average_times_two (average_times_two),
        .spread            (spread),
        .last_result       (last_result)
    );

endmodule

@@ rtl/core/smm_cell.sv @@
// One cell of the suffix min/max chain.
module smm_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] prev_min,
    input  logic signed [SAMPLE_BITS-1:0] prev_max,
    output logic signed [SAMPLE_BITS-1:0] cell_min,
    output logic signed [SAMPLE_BITS-1:0] cell_max
);

    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SAMPLE_BITS-1:0] min_next;
    logic signed [SAMPLE_BITS-1:0] max_next;

    // first sample of a waveform drops the older history
    always_comb
    begin
        if (start)
        begin
            min_next = sample;
            max_next = sample;
        end
        else
        begin
            min_next = (sample < prev_min) ? sample : prev_min;
            max_next = (sample > prev_max) ? sample : prev_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign cell_min = min_reg;
    assign cell_max = max_reg;

endmodule

@@ rtl/core/smm_burst.sv @@
// Output stage: repeats one min/max pair for a group of result beats.
module smm_burst
    import smm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_BITS    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smm_load_t                     ctl,
    input  logic [CNT_BITS-1:0]           load_count,
    input  logic signed [SAMPLE_BITS-1:0] load_min,
    input  logic signed [SAMPLE_BITS-1:0] load_max,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] erosion,
    output logic signed [SAMPLE_BITS-1:0] dilation,
    output logic signed [SAMPLE_BITS:0]   average_times_two,
    output logic [SAMPLE_BITS-1:0]        spread,
    output logic                          last_result
);

    logic [CNT_BITS-1:0]           rem_reg;
    logic [CNT_BITS-1:0]           rem_next;
    logic                          final_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic                          fire;

    assign out_valid = (rem_reg != '0);
    assign fire      = out_valid && !out_stall;
    assign ready     = !out_valid || (rem_reg == CNT_BITS'(1) && !out_stall);

    always_comb
    begin
        rem_next = rem_reg;
        if (ctl.load)
            rem_next = load_count;
        else if (fire)
            rem_next = rem_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (ctl.load)
                final_reg <= ctl.final_grp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            min_reg <= load_min;
            max_reg <= load_max;
        end
    end

    assign erosion           = min_reg;
    assign dilation          = max_reg;
    assign average_times_two = {max_reg[SAMPLE_BITS-1], max_reg}
                             + {min_reg[SAMPLE_BITS-1], min_reg};
    assign spread            = SAMPLE_BITS'(max_reg - min_reg);
    assign last_result       = final_reg && (rem_reg == CNT_BITS'(1));

endmodule

@@ rtl/core/smm_checker.sv @@
// Checker: port-level properties of the sliding min/max filter, bound to the top.
module smm_checker
    import smm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] erosion,
    input logic signed [SAMPLE_BITS-1:0] dilation,
    input logic [SAMPLE_BITS-1:0]        spread,
    input logic                          last_result
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // input only backs up behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // window maximum never below window minimum
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dilation >= erosion)
        else $error("dilation below erosion");

    // spread agrees with the reported pair
    a_spread: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spread == SAMPLE_BITS'(dilation - erosion))
        else $error("spread mismatch");

    // end-of-waveform mark only rides on an offered beat
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> out_valid)
        else $error("last_result without a result beat");

endmodule

bind sliding_min_max_erosion_dilation smm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_smm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .erosion     (erosion),
    .dilation    (dilation),
    .spread      (spread),
    .last_result (last_result)
);
